### rtl/core/two_line_lcd_text_terminal_assert.svh
// Assertion macros for the text terminal
`ifndef TWO_LINE_LCD_TEXT_TERMINAL_ASSERT_SVH
`define TWO_LINE_LCD_TEXT_TERMINAL_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LCDT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LCDT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/lcdterm_pkg.sv
package lcdterm_pkg;

  localparam int ROW_LENGTH_DEF = 16;

  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] CMD_ROW1     = 8'h80;
  localparam logic [7:0] CMD_ROW2     = 8'hC0;
  localparam logic [7:0] CMD_FUNC_SET = 8'h38;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_INIT = 1'b1;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_INIT_A = 4'd1;
  localparam logic [STEP_W-1:0] STEP_INIT_B = 4'd2;
  localparam logic [STEP_W-1:0] STEP_INIT_C = 4'd3;
  localparam logic [STEP_W-1:0] STEP_INIT_D = 4'd4;
  localparam logic [STEP_W-1:0] STEP_INIT_E = 4'd5;
  localparam logic [STEP_W-1:0] STEP_INIT_F = 4'd6;
  localparam logic [STEP_W-1:0] STEP_SCROLL = 4'd7;
  localparam logic [STEP_W-1:0] STEP_WRITE  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_CMD1   = 4'd9;
  localparam logic [STEP_W-1:0] STEP_ROW1   = 4'd10;
  localparam logic [STEP_W-1:0] STEP_CMD2   = 4'd11;
  localparam logic [STEP_W-1:0] STEP_ROW2   = 4'd12;

  localparam logic [1:0] JMP_NEXT      = 2'd0;
  localparam logic [1:0] JMP_DISPATCH  = 2'd1;
  localparam logic [1:0] JMP_ROW_END   = 2'd2;
  localparam logic [1:0] JMP_STORE_END = 2'd3;

  typedef struct packed {
    logic              emit;
    logic              from_store;
    logic [7:0]        cbyte;
    logic              scroll;
    logic              write;
    logic              clear;
    logic              ptr_zero;
    logic              ptr_inc;
    logic [1:0]        jmp;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic       load_char;
    logic       emit;
    logic       from_store;
    logic [7:0] cbyte;
    logic       scroll;
    logic       write;
    logic       clear;
    logic       ptr_zero;
    logic       ptr_inc;
    logic       last;
  } ctrl_t;

  typedef struct packed {
    logic slot_free;
    logic row_end;
    logic store_end;
  } status_t;

  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '0;
    w.jmp = JMP_NEXT;
    w.target = STEP_IDLE;
    case (step)
      STEP_IDLE: begin
        w.jmp = JMP_DISPATCH;
      end
      STEP_INIT_A: begin
        w.emit = 1'b1; w.cbyte = CMD_FUNC_SET; w.target = STEP_INIT_B;
      end
      STEP_INIT_B: begin
        w.emit = 1'b1; w.cbyte = CMD_FUNC_SET; w.target = STEP_INIT_C;
      end
      STEP_INIT_C: begin
        w.emit = 1'b1; w.cbyte = CMD_FUNC_SET; w.target = STEP_INIT_D;
      end
      STEP_INIT_D: begin
        w.emit = 1'b1; w.cbyte = CMD_DISP_ON; w.target = STEP_INIT_E;
      end
      STEP_INIT_E: begin
        w.emit = 1'b1; w.cbyte = CMD_ENTRY; w.target = STEP_INIT_F;
      end
      STEP_INIT_F: begin
        w.emit = 1'b1; w.cbyte = CMD_CLEAR; w.clear = 1'b1; w.ptr_zero = 1'b1;
        w.target = STEP_CMD1;
      end
      STEP_SCROLL: begin
        w.scroll = 1'b1; w.target = STEP_WRITE;
      end
      STEP_WRITE: begin
        w.write = 1'b1; w.ptr_zero = 1'b1; w.target = STEP_CMD1;
      end
      STEP_CMD1: begin
        w.emit = 1'b1; w.cbyte = CMD_ROW1; w.target = STEP_ROW1;
      end
      STEP_ROW1: begin
        w.emit = 1'b1; w.from_store = 1'b1; w.ptr_inc = 1'b1;
        w.jmp = JMP_ROW_END; w.target = STEP_CMD2;
      end
      STEP_CMD2: begin
        w.emit = 1'b1; w.cbyte = CMD_ROW2; w.target = STEP_ROW2;
      end
      STEP_ROW2: begin
        w.emit = 1'b1; w.from_store = 1'b1; w.ptr_inc = 1'b1;
        w.jmp = JMP_STORE_END; w.target = STEP_IDLE;
      end
      default: begin
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/core/lcdterm_seq.sv
module lcdterm_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_opcode,
  output logic                  in_ready,
  input  lcdterm_pkg::status_t  status,
  output lcdterm_pkg::ctrl_t    ctrl
);

  logic [lcdterm_pkg::STEP_W-1:0] step_r;
  logic [lcdterm_pkg::STEP_W-1:0] step_nxt;
  lcdterm_pkg::ucode_t            uw;
  logic                           fire;
  logic                           in_fire;
  logic                           taken;

  assign uw       = lcdterm_pkg::ucode_rom(step_r);
  assign in_ready = (step_r == lcdterm_pkg::STEP_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign fire     = !uw.emit || status.slot_free;

  always_comb begin
    step_nxt = step_r;
    taken    = 1'b0;
    case (uw.jmp)
      lcdterm_pkg::JMP_DISPATCH: begin
        if (in_fire) begin
          step_nxt = (in_opcode == lcdterm_pkg::OP_INIT) ? lcdterm_pkg::STEP_INIT_A
                                                         : lcdterm_pkg::STEP_SCROLL;
        end
      end
      lcdterm_pkg::JMP_NEXT: begin
        taken = fire;
      end
      lcdterm_pkg::JMP_ROW_END: begin
        taken = fire && status.row_end;
      end
      lcdterm_pkg::JMP_STORE_END: begin
        taken = fire && status.store_end;
      end
      default: begin
        taken = 1'b0;
      end
    endcase
    if (taken) begin
      step_nxt = uw.target;
    end
  end

  always_comb begin
    ctrl            = '0;
    ctrl.load_char  = in_fire;
    ctrl.from_store = uw.from_store;
    ctrl.cbyte      = uw.cbyte;
    ctrl.emit       = fire && uw.emit;
    ctrl.scroll     = fire && uw.scroll;
    ctrl.write      = fire && uw.write;
    ctrl.clear      = fire && uw.clear;
    ctrl.ptr_zero   = fire && uw.ptr_zero;
    ctrl.ptr_inc    = fire && uw.ptr_inc;
    ctrl.last       = fire && (uw.jmp == lcdterm_pkg::JMP_STORE_END) && status.store_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= lcdterm_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

### rtl/core/lcdterm_dp.sv
module lcdterm_dp #(
  parameter int ROW_LENGTH = lcdterm_pkg::ROW_LENGTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcdterm_pkg::ctrl_t   ctrl,
  input  logic [7:0]           in_char,
  output lcdterm_pkg::status_t status,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_is_data,
  output logic [7:0]           out_byte,
  output logic                 out_last
);

  localparam int STORE_SIZE = 2 * ROW_LENGTH;
  localparam int AW         = $clog2(STORE_SIZE);
  localparam int PW         = $clog2(STORE_SIZE + 1);
  localparam logic [AW-1:0] ROW_A      = AW'(ROW_LENGTH);
  localparam logic [AW-1:0] ROW_LAST   = AW'(ROW_LENGTH - 1);
  localparam logic [AW-1:0] STORE_LAST = AW'(STORE_SIZE - 1);
  localparam logic [PW-1:0] POS_FULL   = PW'(STORE_SIZE);
  localparam logic [PW-1:0] POS_ROW2   = PW'(ROW_LENGTH);

  logic [7:0]            mem [STORE_SIZE];
  logic [7:0]            rd_r;
  logic                  rd_vld_r;
  logic [STORE_SIZE-1:0] valid_r;
  logic [STORE_SIZE-1:0] valid_nxt;
  logic                  top_r;
  logic                  top_nxt;
  logic [PW-1:0]         pos_r;
  logic [PW-1:0]         pos_nxt;
  logic [AW-1:0]         ptr_r;
  logic [AW-1:0]         ptr_nxt;
  logic [7:0]            char_r;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;
  logic                  out_valid_r;
  logic                  out_is_data_r;
  logic [7:0]            out_byte_r;
  logic                  out_last_r;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] l, input logic top);
    logic          hi;
    logic [AW-1:0] col;
    hi  = (l >= ROW_A);
    col = hi ? (l - ROW_A) : l;
    return (hi ^ top) ? (col + ROW_A) : col;
  endfunction

  assign waddr = phys(pos_r[AW-1:0], top_r);
  assign raddr = phys(ptr_nxt, top_r);

  always_comb begin
    valid_nxt = valid_r;
    top_nxt   = top_r;
    pos_nxt   = pos_r;
    if (ctrl.clear) begin
      valid_nxt = '0;
      top_nxt   = 1'b0;
      pos_nxt   = '0;
    end
    if (ctrl.scroll && (pos_r == POS_FULL)) begin
      for (int i = 0; i < STORE_SIZE; i++) begin
        if (((i >= ROW_LENGTH) ? 1'b1 : 1'b0) == top_r) begin
          valid_nxt[i] = 1'b0;
        end
      end
      top_nxt = !top_r;
      pos_nxt = POS_ROW2;
    end
    if (ctrl.write) begin
      valid_nxt[waddr] = 1'b1;
      pos_nxt          = pos_r + PW'(1);
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (ctrl.ptr_zero) begin
      ptr_nxt = '0;
    end else if (ctrl.ptr_inc) begin
      ptr_nxt = (ptr_r == STORE_LAST) ? '0 : (ptr_r + AW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.write) begin
      mem[waddr] <= char_r;
    end
    rd_r     <= mem[raddr];
    rd_vld_r <= valid_r[raddr];
    if (ctrl.load_char) begin
      char_r <= in_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      top_r       <= 1'b0;
      pos_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      top_r   <= top_nxt;
      pos_r   <= pos_nxt;
      ptr_r   <= ptr_nxt;
      if (ctrl.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_is_data_r <= ctrl.from_store;
      out_byte_r    <= ctrl.from_store ? (rd_vld_r ? rd_r : lcdterm_pkg::SPACE_CHAR)
                                       : ctrl.cbyte;
      out_last_r    <= ctrl.last;
    end
  end

  assign status.slot_free = !out_valid_r || out_ready;
  assign status.row_end   = (ptr_r == ROW_LAST);
  assign status.store_end = (ptr_r == STORE_LAST);

  assign out_valid   = out_valid_r;
  assign out_is_data = out_is_data_r;
  assign out_byte    = out_byte_r;
  assign out_last    = out_last_r;

endmodule

### rtl/core/two_line_lcd_text_terminal.sv
// Channel  Direction  Handshake              Payload
// in_      slave      in_tvalid / in_tready  tuser opcode, tdata char_code
// out_     master     out_tvalid / out_tready tuser is_data, tdata out_byte, tlast last
//
// A put runs the scroll and store-write steps, then sends the row-1 command, the
// first row, the row-2 command and the second row; an initialize first sends the
// setup commands and a clear. Bus bytes go out one per emitting microcode step,
// and such a step stalls while out_tready stays low with a beat waiting.
// Reset clears the per-entry valid bits at once; no clearing pass is run.

`include "two_line_lcd_text_terminal_assert.svh"

module two_line_lcd_text_terminal #(
  parameter int ROW_LENGTH = lcdterm_pkg::ROW_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tuser,   // [0] opcode
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tuser,  // [0] is_data
  output logic       out_tlast
);

  lcdterm_pkg::ctrl_t   ctrl;
  lcdterm_pkg::status_t status;

  lcdterm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_opcode (in_tuser),
    .in_ready  (in_tready),
    .status    (status),
    .ctrl      (ctrl)
  );

  lcdterm_dp #(
    .ROW_LENGTH (ROW_LENGTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .in_char     (in_tdata),
    .status      (status),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .out_is_data (out_tuser),
    .out_byte    (out_tdata),
    .out_last    (out_tlast)
  );

  `LCDT_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready after accept")
  `LCDT_ASSERT_NOW(a_last_is_data, out_tvalid && out_tlast, out_tuser, "final beat not data")
  `LCDT_ASSERT_NOW(a_accept_drained, in_tvalid && in_tready, !(out_tvalid && !out_tlast), "accept mid-refresh")

endmodule
